// ===== hdl/mp2d_pkg.sv =====
`default_nettype none

package mp2d_pkg;

  localparam int unsigned WIDTH_MAX  = 256;
  localparam int unsigned HEIGHT_MAX = 256;
  localparam int unsigned CHAN_MAX   = 64;
  localparam int unsigned POOL_MAX   = 4;

  localparam int unsigned PIX_W      = 16;
  localparam int unsigned STORE_DEPTH = POOL_MAX * WIDTH_MAX;
  localparam int unsigned STORE_AW   = $clog2(STORE_DEPTH);

  // register map, byte address = 4 * index
  typedef enum logic [2:0] {
    REG_IMG_H   = 3'd0,
    REG_IMG_W   = 3'd1,
    REG_CHANS   = 3'd2,
    REG_POOL_H  = 3'd3,
    REG_POOL_W  = 3'd4,
    REG_VSTRIDE = 3'd5,
    REG_HSTRIDE = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_ROW,
    ST_DIV_COL,
    ST_READ,
    ST_FLUSH,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/mp2d_ram.sv =====
`default_nettype none

module mp2d_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned DEPTH  = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/max_pool_2d.sv =====
`default_nettype none

// Sequence: a pixel that closes no window leaves in_tready high; one that closes a window
//   runs a row divide, a column divide, line store reads, a flush and the output load.
// Throughput: one pixel at a time; in_tready is low until the sequencer is back in idle:
//   after the divides off the stride grid, else once the output register takes the result.
// Reset: synchronous, active low; clears counters, sequencer and output valid, loads the
//   register defaults. Line store contents are not cleared.

module max_pool_2d (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] pixel_value
  input  wire logic        in_tuser,   // [0] start_of_image
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [15:0] pooled_max, [23:16] out_row,
                                       // [31:24] out_col, [37:32] out_channel, [39:38] zero
  output logic             out_tlast,  // last_of_image
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned AW = mp2d_pkg::STORE_AW;

  // configuration registers
  logic [8:0] reg_h_r, reg_w_r;
  logic [6:0] reg_nc_r;
  logic [2:0] reg_ph_r, reg_pw_r, reg_vs_r, reg_hs_r;

  logic [8:0] h_eff, w_eff;
  logic [6:0] nc_eff;
  logic [2:0] ph_eff, pw_eff, vs_eff, hs_eff;

  // sequencer and position state
  mp2d_pkg::state_t state_r, state_nxt;
  logic [7:0]  row_r, row_nxt, col_r, col_nxt;
  logic [5:0]  chan_r, chan_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [1:0]  rr_r, rr_nxt, cc_r, cc_nxt;
  logic        rd_vld_r, rd_vld_nxt;
  logic        out_vld_r, out_vld_nxt;

  // working payload
  logic [7:0]  r0_r, r0_nxt, c0_r, c0_nxt;
  logic [5:0]  wchan_r, wchan_nxt;
  logic        wlast_r, wlast_nxt;
  logic signed [15:0] best_r, best_nxt;
  logic [7:0]  dq_r, dq_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic [7:0]  row_q_r, row_q_nxt;
  logic        row_rz_r, row_rz_nxt;
  logic [39:0] out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;

  // shared compare unit
  logic signed [15:0] cmp_a, cmp_b;
  logic               cmp_lt;

  logic          in_acc, cfg_wr, out_load;
  logic [7:0]    cur_row, cur_col;
  logic [5:0]    cur_chan;
  logic [8:0]    col_p1, row_p1;
  logic [6:0]    chan_p1;
  logic          emit;
  logic [7:0]    r0_c, c0_c;
  logic [3:0]    cand;
  logic [2:0]    divisor;
  logic          div_ge;
  logic [2:0]    rem_step;
  logic [7:0]    dq_step;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  // ---------------------------------------------------------------- config
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_h_r  <= 9'd28;
      reg_w_r  <= 9'd28;
      reg_nc_r <= 7'd1;
      reg_ph_r <= 3'd2;
      reg_pw_r <= 3'd2;
      reg_vs_r <= 3'd2;
      reg_hs_r <= 3'd2;
    end else if (cfg_wr) begin
      case (mp2d_pkg::reg_idx_t'(cfg_paddr[4:2]))
        mp2d_pkg::REG_IMG_H:   reg_h_r  <= cfg_pwdata[8:0];
        mp2d_pkg::REG_IMG_W:   reg_w_r  <= cfg_pwdata[8:0];
        mp2d_pkg::REG_CHANS:   reg_nc_r <= cfg_pwdata[6:0];
        mp2d_pkg::REG_POOL_H:  reg_ph_r <= cfg_pwdata[2:0];
        mp2d_pkg::REG_POOL_W:  reg_pw_r <= cfg_pwdata[2:0];
        mp2d_pkg::REG_VSTRIDE: reg_vs_r <= cfg_pwdata[2:0];
        mp2d_pkg::REG_HSTRIDE: reg_hs_r <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mp2d_pkg::reg_idx_t'(cfg_paddr[4:2]))
      mp2d_pkg::REG_IMG_H:   cfg_prdata = {23'd0, reg_h_r};
      mp2d_pkg::REG_IMG_W:   cfg_prdata = {23'd0, reg_w_r};
      mp2d_pkg::REG_CHANS:   cfg_prdata = {25'd0, reg_nc_r};
      mp2d_pkg::REG_POOL_H:  cfg_prdata = {29'd0, reg_ph_r};
      mp2d_pkg::REG_POOL_W:  cfg_prdata = {29'd0, reg_pw_r};
      mp2d_pkg::REG_VSTRIDE: cfg_prdata = {29'd0, reg_vs_r};
      mp2d_pkg::REG_HSTRIDE: cfg_prdata = {29'd0, reg_hs_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  // zero acts as one, oversize saturates
  always_comb begin
    h_eff  = (reg_h_r == 9'd0) ? 9'd1 :
             (reg_h_r > 9'(mp2d_pkg::HEIGHT_MAX)) ? 9'(mp2d_pkg::HEIGHT_MAX) : reg_h_r;
    w_eff  = (reg_w_r == 9'd0) ? 9'd1 :
             (reg_w_r > 9'(mp2d_pkg::WIDTH_MAX)) ? 9'(mp2d_pkg::WIDTH_MAX) : reg_w_r;
    nc_eff = (reg_nc_r == 7'd0) ? 7'd1 :
             (reg_nc_r > 7'(mp2d_pkg::CHAN_MAX)) ? 7'(mp2d_pkg::CHAN_MAX) : reg_nc_r;
    ph_eff = (reg_ph_r == 3'd0) ? 3'd1 :
             (reg_ph_r > 3'(mp2d_pkg::POOL_MAX)) ? 3'(mp2d_pkg::POOL_MAX) : reg_ph_r;
    pw_eff = (reg_pw_r == 3'd0) ? 3'd1 :
             (reg_pw_r > 3'(mp2d_pkg::POOL_MAX)) ? 3'(mp2d_pkg::POOL_MAX) : reg_pw_r;
    vs_eff = (reg_vs_r == 3'd0) ? 3'd1 : reg_vs_r;
    hs_eff = (reg_hs_r == 3'd0) ? 3'd1 : reg_hs_r;
  end

  // ---------------------------------------------------------------- line store
  assign in_tready = (state_r == mp2d_pkg::ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  assign cur_row  = in_tuser ? 8'd0 : row_r;
  assign cur_col  = in_tuser ? 8'd0 : col_r;
  assign cur_chan = in_tuser ? 6'd0 : chan_r;

  assign ram_raddr = {2'(r0_r[1:0] + rr_r), 8'(c0_r + {6'd0, cc_r})};

  mp2d_ram #(
    .DATA_W(mp2d_pkg::PIX_W),
    .DEPTH (mp2d_pkg::STORE_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (in_acc),
    .waddr({cur_row[1:0], cur_col}),
    .wdata(in_tdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // ---------------------------------------------------------------- window check
  assign col_p1  = {1'b0, cur_col} + 9'd1;
  assign row_p1  = {1'b0, cur_row} + 9'd1;
  assign chan_p1 = {1'b0, cur_chan} + 7'd1;

  assign emit = ({1'b0, cur_row} < h_eff) && ({1'b0, cur_col} < w_eff) &&
                ({1'b0, cur_chan} < nc_eff) &&
                (row_p1 >= {6'd0, ph_eff}) && (col_p1 >= {6'd0, pw_eff});

  assign r0_c = cur_row - 8'(ph_eff - 3'd1);
  assign c0_c = cur_col - 8'(pw_eff - 3'd1);

  // ---------------------------------------------------------------- shared compare
  assign divisor = (state_r == mp2d_pkg::ST_DIV_ROW) ? vs_eff : hs_eff;
  assign cand    = {rem_r, dq_r[7]};

  always_comb begin
    if (state_r == mp2d_pkg::ST_DIV_ROW || state_r == mp2d_pkg::ST_DIV_COL) begin
      cmp_a = $signed({12'd0, cand});
      cmp_b = $signed({13'd0, divisor});
    end else begin
      cmp_a = best_r;
      cmp_b = $signed(ram_rdata);
    end
  end

  assign cmp_lt   = (cmp_a < cmp_b);
  assign div_ge   = !cmp_lt;
  assign rem_step = div_ge ? 3'(cand - {1'b0, divisor}) : cand[2:0];
  assign dq_step  = {dq_r[6:0], div_ge};

  // ---------------------------------------------------------------- sequencer
  assign out_load = (state_r == mp2d_pkg::ST_FINISH) && (!out_vld_r || out_tready);

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    chan_nxt     = chan_r;
    step_nxt     = step_r;
    rr_nxt       = rr_r;
    cc_nxt       = cc_r;
    rd_vld_nxt   = 1'b0;
    r0_nxt       = r0_r;
    c0_nxt       = c0_r;
    wchan_nxt    = wchan_r;
    wlast_nxt    = wlast_r;
    best_nxt     = best_r;
    dq_nxt       = dq_r;
    rem_nxt      = rem_r;
    row_q_nxt    = row_q_r;
    row_rz_nxt   = row_rz_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    out_vld_nxt  = out_tready ? 1'b0 : out_vld_r;

    case (state_r)
      mp2d_pkg::ST_IDLE: begin
        if (in_acc) begin
          // advance raster position
          if (col_p1 >= w_eff) begin
            col_nxt = 8'd0;
            if (row_p1 >= h_eff) begin
              row_nxt  = 8'd0;
              chan_nxt = (chan_p1 >= nc_eff) ? 6'd0 : chan_p1[5:0];
            end else begin
              row_nxt  = row_p1[7:0];
              chan_nxt = cur_chan;
            end
          end else begin
            col_nxt  = col_p1[7:0];
            row_nxt  = cur_row;
            chan_nxt = cur_chan;
          end
          r0_nxt    = r0_c;
          c0_nxt    = c0_c;
          wchan_nxt = cur_chan;
          best_nxt  = $signed(in_tdata);
          wlast_nxt = ({1'b0, cur_chan} == nc_eff - 7'd1) &&
                      ({2'd0, r0_c} + {7'd0, vs_eff} > {1'b0, h_eff} - {7'd0, ph_eff}) &&
                      ({2'd0, c0_c} + {7'd0, hs_eff} > {1'b0, w_eff} - {7'd0, pw_eff});
          dq_nxt    = r0_c;
          rem_nxt   = 3'd0;
          step_nxt  = 3'd0;
          if (emit) begin
            state_nxt = mp2d_pkg::ST_DIV_ROW;
          end
        end
      end

      mp2d_pkg::ST_DIV_ROW: begin
        dq_nxt   = dq_step;
        rem_nxt  = rem_step;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          row_q_nxt  = dq_step;
          row_rz_nxt = (rem_step == 3'd0);
          dq_nxt     = c0_r;
          rem_nxt    = 3'd0;
          state_nxt  = mp2d_pkg::ST_DIV_COL;
        end
      end

      mp2d_pkg::ST_DIV_COL: begin
        dq_nxt   = dq_step;
        rem_nxt  = rem_step;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          rr_nxt = 2'd0;
          cc_nxt = 2'd0;
          // drop windows off the stride grid
          if (row_rz_r && rem_step == 3'd0) begin
            state_nxt = mp2d_pkg::ST_READ;
          end else begin
            state_nxt = mp2d_pkg::ST_IDLE;
          end
        end
      end

      mp2d_pkg::ST_READ: begin
        rd_vld_nxt = 1'b1;
        if (rd_vld_r && cmp_lt) begin
          best_nxt = $signed(ram_rdata);
        end
        if (cc_r == 2'(pw_eff - 3'd1)) begin
          cc_nxt = 2'd0;
          rr_nxt = rr_r + 2'd1;
          if (rr_r == 2'(ph_eff - 3'd1)) begin
            state_nxt = mp2d_pkg::ST_FLUSH;
          end
        end else begin
          cc_nxt = cc_r + 2'd1;
        end
      end

      mp2d_pkg::ST_FLUSH: begin
        if (rd_vld_r && cmp_lt) begin
          best_nxt = $signed(ram_rdata);
        end
        state_nxt = mp2d_pkg::ST_FINISH;
      end

      mp2d_pkg::ST_FINISH: begin
        if (out_load) begin
          out_data_nxt = {2'd0, wchan_r, dq_r, row_q_r, best_r};
          out_last_nxt = wlast_r;
          out_vld_nxt  = 1'b1;
          state_nxt    = mp2d_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mp2d_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mp2d_pkg::ST_IDLE;
      row_r     <= 8'd0;
      col_r     <= 8'd0;
      chan_r    <= 6'd0;
      step_r    <= 3'd0;
      rr_r      <= 2'd0;
      cc_r      <= 2'd0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      chan_r    <= chan_nxt;
      step_r    <= step_nxt;
      rr_r      <= rr_nxt;
      cc_r      <= cc_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r0_r       <= r0_nxt;
    c0_r       <= c0_nxt;
    wchan_r    <= wchan_nxt;
    wlast_r    <= wlast_nxt;
    best_r     <= best_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    row_q_r    <= row_q_nxt;
    row_rz_r   <= row_rz_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_read_in_window_phase: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == mp2d_pkg::ST_READ || state_r == mp2d_pkg::ST_FLUSH))
    else $error("line store read data outside window scan");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(state_r) == mp2d_pkg::ST_FINISH))
    else $error("result raised without a finished window");

  a_row_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mp2d_pkg::ST_DIV_ROW) |-> (rem_r < vs_eff))
    else $error("row divide remainder not below stride");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mp2d_pkg::ST_DIV_ROW && step_r != 3'd7) |=>
      (state_r == mp2d_pkg::ST_DIV_ROW && !in_tready))
    else $error("row divide left early");
`endif

endmodule

`default_nettype wire

// ===== test/max_pool_2d_test.sv =====
`default_nettype none

module max_pool_2d_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REG_COUNT    = 7;
  localparam int unsigned ITEM_TARGET  = 1100;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned SETTLE_WAIT  = 40;
  localparam int unsigned DRAIN_LIMIT  = 2000;
  localparam int unsigned MAX_PRINTED  = 100;

  typedef struct packed {
    logic [15:0] max_val;
    logic [7:0]  row_idx;
    logic [7:0]  col_idx;
    logic [5:0]  chan_idx;
    logic        is_last;
  } window_t;

  class max_pool_scoreboard;
    logic [15:0] line_buf [mp2d_pkg::POOL_MAX][mp2d_pkg::WIDTH_MAX];
    int unsigned reg_val [REG_COUNT];
    int unsigned cur_row, cur_col, cur_chan;
    window_t     due_windows [$];
    int unsigned errors;
    int unsigned windows_seen;

    function new();
      reg_val = '{28, 28, 1, 2, 2, 2, 2};
      cur_row = 0;
      cur_col = 0;
      cur_chan = 0;
      errors = 0;
      windows_seen = 0;
    endfunction

    function void set_reg(mp2d_pkg::reg_idx_t idx, int unsigned value);
      case (idx)
        mp2d_pkg::REG_IMG_H, mp2d_pkg::REG_IMG_W: reg_val[idx] = value & 32'h1FF;
        mp2d_pkg::REG_CHANS:                      reg_val[idx] = value & 32'h7F;
        default:                                  reg_val[idx] = value & 32'h7;
      endcase
    endfunction

    // zero acts as one, oversize saturates
    function int unsigned usable(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void predict_window(logic [15:0] pix, logic soi);
      int unsigned h, w, nc, ph, pw, vs, hs, r0, c0, rr, cc;
      logic signed [15:0] best, v;
      window_t win;
      h  = usable(reg_val[mp2d_pkg::REG_IMG_H], mp2d_pkg::HEIGHT_MAX);
      w  = usable(reg_val[mp2d_pkg::REG_IMG_W], mp2d_pkg::WIDTH_MAX);
      nc = usable(reg_val[mp2d_pkg::REG_CHANS], mp2d_pkg::CHAN_MAX);
      ph = usable(reg_val[mp2d_pkg::REG_POOL_H], mp2d_pkg::POOL_MAX);
      pw = usable(reg_val[mp2d_pkg::REG_POOL_W], mp2d_pkg::POOL_MAX);
      vs = usable(reg_val[mp2d_pkg::REG_VSTRIDE], 7);
      hs = usable(reg_val[mp2d_pkg::REG_HSTRIDE], 7);
      if (soi) begin
        cur_row = 0;
        cur_col = 0;
        cur_chan = 0;
      end
      line_buf[cur_row % mp2d_pkg::POOL_MAX][cur_col % mp2d_pkg::WIDTH_MAX] = pix;
      if (cur_row < h && cur_col < w && cur_chan < nc &&
          cur_row + 1 >= ph && cur_col + 1 >= pw) begin
        r0 = cur_row + 1 - ph;
        c0 = cur_col + 1 - pw;
        if (r0 % vs == 0 && c0 % hs == 0) begin
          best = pix;
          for (rr = r0; rr <= cur_row; rr++) begin
            for (cc = c0; cc <= cur_col; cc++) begin
              v = line_buf[rr % mp2d_pkg::POOL_MAX][cc % mp2d_pkg::WIDTH_MAX];
              if (v > best) best = v;
            end
          end
          win.max_val  = best;
          win.row_idx  = 8'(r0 / vs);
          win.col_idx  = 8'(c0 / hs);
          win.chan_idx = 6'(cur_chan);
          win.is_last  = (cur_chan == nc - 1) && (r0 + vs > h - ph) && (c0 + hs > w - pw);
          due_windows.push_back(win);
        end
      end
      // advance raster position
      cur_col++;
      if (cur_col >= w) begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= h) begin
          cur_row = 0;
          cur_chan++;
          if (cur_chan >= nc) cur_chan = 0;
        end
      end
    endfunction

    task report(string what);
      if (errors < MAX_PRINTED) $display("%0t MISMATCH %s", $time, what);
      errors++;
    endtask

    task check_window(logic [39:0] data, logic last_flag);
      window_t want;
      windows_seen++;
      if (due_windows.size() == 0) begin
        report($sformatf("window %0d not expected: max %h row %0d col %0d ch %0d last %b",
                         windows_seen, data[15:0], data[23:16], data[31:24], data[37:32],
                         last_flag));
        return;
      end
      want = due_windows.pop_front();
      if (data[15:0] !== want.max_val)
        report($sformatf("window %0d max %h, want %h", windows_seen, data[15:0], want.max_val));
      if (data[23:16] !== want.row_idx)
        report($sformatf("window %0d row %0d, want %0d", windows_seen, data[23:16],
                         want.row_idx));
      if (data[31:24] !== want.col_idx)
        report($sformatf("window %0d col %0d, want %0d", windows_seen, data[31:24],
                         want.col_idx));
      if (data[37:32] !== want.chan_idx)
        report($sformatf("window %0d channel %0d, want %0d", windows_seen, data[37:32],
                         want.chan_idx));
      if (last_flag !== want.is_last)
        report($sformatf("window %0d last %b, want %b", windows_seen, last_flag,
                         want.is_last));
    endtask

    task drop_missing();
      window_t want;
      while (due_windows.size() != 0) begin
        want = due_windows.pop_front();
        report($sformatf("window never came: max %h row %0d col %0d ch %0d",
                         want.max_val, want.row_idx, want.col_idx, want.chan_idx));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] pixel_value
  logic        in_tuser;   // [0] start_of_image
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [15:0] pooled_max, [23:16] out_row, [31:24] out_col,
                           // [37:32] out_channel, [39:38] zero
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  max_pool_scoreboard sb;
  int unsigned cfg_plan [REG_COUNT];
  int unsigned pixels_sent = 0;
  int unsigned hold_requests = 0;
  int unsigned cycle_count = 0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;

  max_pool_2d DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("max_pool_2d test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.predict_window(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) sb.check_window(out_tdata, out_tlast);
  end

  function automatic int unsigned pick_gap(bit steady);
    int unsigned p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] random_pixel();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // out-of-range encodings that the block must treat as the same setting
  function automatic int unsigned raw_for(int unsigned e, int unsigned maxv, int unsigned mask);
    if (e == 1 && $urandom_range(0, 4) == 0) return 0;
    if (e == maxv && maxv < mask && $urandom_range(0, 1) == 1)
      return $urandom_range(maxv + 1, mask);
    return e;
  endfunction

  function automatic void set_plan(int unsigned h, int unsigned w, int unsigned nc,
                                   int unsigned ph, int unsigned pw,
                                   int unsigned vs, int unsigned hs);
    cfg_plan = '{h, w, nc, ph, pw, vs, hs};
  endfunction

  task automatic write_reg(mp2d_pkg::reg_idx_t idx, int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_plan();
    for (int i = 0; i < REG_COUNT; i++) write_reg(mp2d_pkg::reg_idx_t'(i), cfg_plan[i]);
  endtask

  task automatic send_pixel(logic [15:0] pix, logic soi);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= soi;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
    gap = pick_gap(src_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic pixel_run(int unsigned count, bit soi_first, bit noisy);
    src_steady  = ($urandom_range(0, 3) == 0);
    sink_steady = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < count; i++)
      send_pixel(random_pixel(), (i == 0) ? soi_first : (noisy && $urandom_range(0, 59) == 0));
    in_tvalid <= 1'b0;
  endtask

  // drain expected windows, then cover a pixel that may still be in flight
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while (sb.due_windows.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    sb.drop_missing();
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic random_phase();
    int unsigned eh, ew, enc, eph, epw, n_img, count, pick;
    eh  = $urandom_range(1, 8);
    ew  = $urandom_range(1, 12);
    enc = $urandom_range(1, 3);
    eph = $urandom_range(1, 4);
    epw = $urandom_range(1, 4);
    set_plan(raw_for(eh, mp2d_pkg::HEIGHT_MAX, 511), raw_for(ew, mp2d_pkg::WIDTH_MAX, 511),
             raw_for(enc, mp2d_pkg::CHAN_MAX, 127), raw_for(eph, mp2d_pkg::POOL_MAX, 7),
             raw_for(epw, mp2d_pkg::POOL_MAX, 7),
             ($urandom_range(0, 9) == 0) ? 0 :
               (($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4)),
             ($urandom_range(0, 9) == 0) ? 0 :
               (($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4)));
    apply_plan();
    n_img = eh * ew * enc;
    pick = $urandom_range(0, 9);
    if (pick < 6) count = n_img;
    else if (pick < 8) count = 2 * n_img;
    else count = $urandom_range(1, n_img);
    pixel_run(count, 1'b1, $urandom_range(0, 1));
    settle();
  endtask

  // ready runs and stalls; one long hold-off when asked
  initial begin : result_sink
    int unsigned holds_done;
    int unsigned run_len, stall_len;
    holds_done = 0;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_requests != holds_done) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      run_len = $urandom_range(1, 20);
      out_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap(sink_steady);
      if (stall_len > 0) begin
        out_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    sb = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults, part of a 28x28 image
    pixel_run(60, 1'b1, 1'b0);
    settle();

    // 2x2 windows over extremes: one negative max, one positive max
    set_plan(2, 3, 1, 2, 2, 1, 1);
    apply_plan();
    send_pixel(16'h8000, 1'b1);
    send_pixel(16'hFFFE, 1'b0);
    send_pixel(16'h7FFF, 1'b0);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    in_tvalid <= 1'b0;
    settle();

    // pool taller than the image: nothing comes out
    set_plan(1, 3, 1, 2, 2, 1, 1);
    apply_plan();
    pixel_run(3, 1'b1, 1'b0);
    settle();

    // all registers zero act as one
    set_plan(0, 0, 0, 0, 0, 0, 0);
    apply_plan();
    pixel_run(2, 1'b1, 1'b0);
    settle();

    // shrink the height in mid-image: the rest of that row lies outside, then wrap
    set_plan(4, 2, 1, 1, 1, 1, 1);
    apply_plan();
    pixel_run(6, 1'b1, 1'b0);
    settle();
    write_reg(mp2d_pkg::REG_IMG_H, 2);
    pixel_run(6, 1'b0, 1'b0);
    settle();

    // full width with the receiver holding off at the start
    set_plan(1, 511, 1, 1, 1, 1, 1);
    apply_plan();
    hold_requests++;
    pixel_run(256, 1'b1, 1'b0);
    settle();

    // full height
    set_plan(300, 1, 1, 1, 1, 1, 1);
    apply_plan();
    pixel_run(256, 1'b1, 1'b0);
    settle();

    // every channel plane
    set_plan(1, 1, 127, 1, 1, 1, 1);
    apply_plan();
    pixel_run(64, 1'b1, 1'b0);
    settle();

    while (pixels_sent < ITEM_TARGET) random_phase();

    settle();
    if (sb.errors == 0) begin
      $display("max_pool_2d test passed");
    end else begin
      $display("max_pool_2d test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/mp2d_pkg.sv
hdl/mp2d_ram.sv
hdl/max_pool_2d.sv
test/max_pool_2d_test.sv
